[sv/ptts_pkg.sv]
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes for the periodic task table scheduler: opcodes,
// result codes, task states and the layout of one slot table entry.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int unsigned OPCODE_W      = 3;
   localparam int unsigned TASK_ID_W     = 8;
   localparam int unsigned PERIOD_W      = 16;
   localparam int unsigned RESULT_CODE_W = 3;
   localparam int unsigned TASK_STATE_W  = 2;
   localparam int unsigned TICK_DIV_W    = 16;

   localparam logic [TICK_DIV_W-1:0] TICK_DIVIDE_RESET = 16'd100;

   localparam logic [OPCODE_W-1:0] OP_ADD      = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DISPATCH = 3'd4;

   localparam logic [RESULT_CODE_W-1:0] RC_DONE      = 3'd0;
   localparam logic [RESULT_CODE_W-1:0] RC_FULL      = 3'd1;
   localparam logic [RESULT_CODE_W-1:0] RC_NOT_FOUND = 3'd2;
   localparam logic [RESULT_CODE_W-1:0] RC_NONE_DUE  = 3'd3;
   localparam logic [RESULT_CODE_W-1:0] RC_DUE       = 3'd4;

   localparam logic [TASK_STATE_W-1:0] TS_STOPPED = 2'd0;
   localparam logic [TASK_STATE_W-1:0] TS_READY   = 2'd1;

   typedef struct packed {
      logic                  active;
      logic [TASK_ID_W-1:0]  ident;
      logic [PERIOD_W-1:0]   countdown;
      logic [PERIOD_W-1:0]   reload;
   } slot_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } seq_state_type;

endpackage

[sv/periodic_task_table_scheduler.sv]
// ----------------------------------------------------------------------------
// periodic_task_table_scheduler
// Table of periodic task slots held in a synchronous memory with one read and
// one write port. Each item with opcode 0 to 4 scans the slots in order
// through a read, modify, write pipeline and returns one result beat, or one
// beat per due task for dispatch.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | opcode, task_id, period
//  rsp     | out       | rsp_valid / rsp_ready  | result_code, due_id,
//          |           |                        | task_state, last
//  csr     | in        | csr_wr_en              | tick_divide (csr_wr_data)
//
//  An item scans the slots at one slot read a cycle unless the scan stalls,
//  then posts the final result from the finish state and returns to idle to
//  accept the next item. Opcodes 5 to 7 are accepted and dropped with no
//  result.
//  A full output register stalls the scan on a second due task and holds
//  the final result until taken. Reset clears the slot valid bits (slots
//  read as zero until written), the prescaler and sets tick_divide to 100.
//  req_ready is high only between items.
// ----------------------------------------------------------------------------
module periodic_task_table_scheduler #(
   parameter int unsigned TASK_SLOTS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ptts_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [ptts_pkg::TASK_ID_W-1:0]     req_task_id,
   input  logic [ptts_pkg::PERIOD_W-1:0]      req_period,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ptts_pkg::RESULT_CODE_W-1:0] rsp_result_code,
   output logic [ptts_pkg::TASK_ID_W-1:0]     rsp_due_id,
   output logic [ptts_pkg::TASK_STATE_W-1:0]  rsp_task_state,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [ptts_pkg::TICK_DIV_W-1:0]    csr_wr_data
);
   import ptts_pkg::*;

   localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(TASK_SLOTS);

   seq_state_type                state_ff, state_in;
   logic [TICK_DIV_W-1:0]        tick_div_ff;
   logic [TICK_DIV_W-1:0]        prescale_ff, prescale_in;
   logic [OPCODE_W-1:0]          op_ff;
   logic [TASK_ID_W-1:0]         id_ff;
   logic [PERIOD_W-1:0]          per_ff;
   logic                         fire_ff, fire_in;
   logic [CNT_W-1:0]             rd_addr_ff, rd_addr_in;
   logic                         eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]             eval_addr_ff, eval_addr_in;
   logic                         hit_ff, hit_in;
   logic                         hit_active_ff, hit_active_in;
   logic                         pend_vld_ff, pend_vld_in;
   logic [TASK_ID_W-1:0]         pend_id_ff, pend_id_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RESULT_CODE_W-1:0]     rsp_code_ff, rsp_code_in;
   logic [TASK_ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic [TASK_STATE_W-1:0]      rsp_state_ff, rsp_state_in;
   logic                         rsp_last_ff, rsp_last_in;

   slot_entry_type               slot_mem [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]        slot_vld_ff;
   slot_entry_type               rd_data_ff;
   logic                         rd_vld_ff;

   logic                         req_accept;
   logic                         out_free;
   logic                         rd_en;
   logic                         mem_we;
   slot_entry_type               wr_data;
   slot_entry_type               cur;
   logic                         due;
   logic                         stall;
   logic [TICK_DIV_W-1:0]        prescale_inc;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_due_id      = rsp_id_ff;
   assign rsp_task_state  = rsp_state_ff;
   assign rsp_last        = rsp_last_ff;

   assign cur   = rd_vld_ff ? rd_data_ff : '0;
   assign due   = eval_vld_ff && (op_ff == OP_DISPATCH) && cur.active &&
                  (cur.countdown == '0);
   assign stall = due && pend_vld_ff && !out_free;
   assign prescale_inc = prescale_ff + TICK_DIV_W'(1);

   // slot memory: one read and one write port, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[eval_addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            slot_vld_ff[eval_addr_ff] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= slot_vld_ff[rd_addr_ff[IDX_W-1:0]];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      prescale_in   = prescale_ff;
      fire_in       = fire_ff;
      rd_addr_in    = rd_addr_ff;
      eval_vld_in   = eval_vld_ff;
      eval_addr_in  = eval_addr_ff;
      hit_in        = hit_ff;
      hit_active_in = hit_active_ff;
      pend_vld_in   = pend_vld_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_code_in   = rsp_code_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      wr_data       = cur;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_opcode <= OP_DISPATCH)) begin
               state_in    = ST_SCAN;
               rd_addr_in  = '0;
               eval_vld_in = 1'b0;
               hit_in      = 1'b0;
               pend_vld_in = 1'b0;
               fire_in     = 1'b0;
               if (req_opcode == OP_TICK) begin
                  if (prescale_inc == tick_div_ff) begin
                     fire_in     = 1'b1;
                     prescale_in = '0;
                  end else begin
                     prescale_in = prescale_inc;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (eval_vld_ff) begin
                  unique case (op_ff)
                     OP_ADD: begin
                        if (!hit_ff && !cur.active) begin
                           hit_in            = 1'b1;
                           mem_we            = 1'b1;
                           wr_data.active    = 1'b1;
                           wr_data.ident     = id_ff;
                           wr_data.countdown = per_ff;
                           wr_data.reload    = per_ff;
                        end
                     end
                     OP_DELETE: begin
                        if (!hit_ff && (cur.ident == id_ff)) begin
                           hit_in         = 1'b1;
                           mem_we         = 1'b1;
                           wr_data.active = 1'b0;
                        end
                     end
                     OP_QUERY: begin
                        if (!hit_ff && (cur.ident == id_ff)) begin
                           hit_in        = 1'b1;
                           hit_active_in = cur.active;
                        end
                     end
                     OP_TICK: begin
                        if (fire_ff && cur.active && (cur.countdown != '0)) begin
                           mem_we            = 1'b1;
                           wr_data.countdown = cur.countdown - PERIOD_W'(1);
                        end
                     end
                     default: begin
                        if (due) begin
                           mem_we            = 1'b1;
                           wr_data.countdown = cur.reload;
                           pend_vld_in       = 1'b1;
                           pend_id_in        = cur.ident;
                           if (pend_vld_ff) begin
                              rsp_valid_in = 1'b1;
                              rsp_code_in  = RC_DUE;
                              rsp_id_in    = pend_id_ff;
                              rsp_state_in = TS_STOPPED;
                              rsp_last_in  = 1'b0;
                           end
                        end
                     end
                  endcase
               end
               if (rd_addr_ff < SLOT_END) begin
                  rd_en        = 1'b1;
                  eval_vld_in  = 1'b1;
                  eval_addr_in = rd_addr_ff[IDX_W-1:0];
                  rd_addr_in   = rd_addr_ff + CNT_W'(1);
               end else begin
                  eval_vld_in = 1'b0;
                  state_in    = ST_FINISH;
               end
            end
         end
         default: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               pend_vld_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_state_in = TS_STOPPED;
               rsp_last_in  = 1'b1;
               unique case (op_ff)
                  OP_ADD:    rsp_code_in = hit_ff ? RC_DONE : RC_FULL;
                  OP_DELETE: rsp_code_in = hit_ff ? RC_DONE : RC_NOT_FOUND;
                  OP_QUERY: begin
                     rsp_code_in = hit_ff ? RC_DONE : RC_NOT_FOUND;
                     if (hit_ff && hit_active_ff) begin
                        rsp_state_in = TS_READY;
                     end
                  end
                  OP_TICK:   rsp_code_in = RC_DONE;
                  default: begin
                     if (pend_vld_ff) begin
                        rsp_code_in = RC_DUE;
                        rsp_id_in   = pend_id_ff;
                     end else begin
                        rsp_code_in = RC_NONE_DUE;
                        rsp_id_in   = '0;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_div_ff  <= TICK_DIVIDE_RESET;
         prescale_ff  <= '0;
         rd_addr_ff   <= '0;
         eval_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prescale_ff  <= prescale_in;
         rd_addr_ff   <= rd_addr_in;
         eval_vld_ff  <= eval_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tick_div_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_opcode;
         id_ff  <= req_task_id;
         per_ff <= req_period;
      end
      fire_ff       <= fire_in;
      eval_addr_ff  <= eval_addr_in;
      hit_ff        <= hit_in;
      hit_active_ff <= hit_active_in;
      pend_id_ff    <= pend_id_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("pending due task left over between items");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_SCAN) && eval_vld_ff && !stall))
      else $error("slot write outside an active scan step");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_addr_ff < SLOT_END))
      else $error("slot read beyond the table");

   a_finish_posts: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final result not posted");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(rsp_code_ff) && $stable(rsp_id_ff)))
      else $error("waiting result overwritten");

endmodule
